>>> design/rmf_pkg.sv
package rmf_pkg;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_HEADER  = 4'd1,
    PH_CHAN    = 4'd2,
    PH_LEN_HI  = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_PAYLOAD = 4'd5,
    PH_SKIP    = 4'd6,
    PH_BODY    = 4'd7
  } phase_e;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;

  // Match position codes: 0..13 walk the key, then two special codes.
  localparam logic [3:0] KEY_LAST   = 4'd13;
  localparam logic [3:0] POS_SKIP   = 4'd14;
  localparam logic [3:0] POS_DIGITS = 4'd15;

  // Lower-case "content-length", one character per match position.
  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (pos)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h6C; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? (b | 8'h20) : b;
  endfunction

endpackage

>>> design/rtsp_message_framer_top.sv
// A result is registered into the output register, or into the skid entry while the
//   output register is held, from the byte that ends the message.
// Throughput: one byte per cycle while in_ready_o is high; per-byte parse state updates in a single pass.
//   A two-entry output buffer (output register plus skid) keeps input flowing
//   while one result waits downstream.
// Reset: rst_ni is asynchronous, active low; parser idle, buffer empty, interleave off.
module rtsp_message_framer_top #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  // byte stream in
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  // message results out
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [LENGTH_BITS-1:0] msg_length_o,
  output logic                   is_frame_o,
  output logic [7:0]             frame_channel_o,
  output logic [LENGTH_BITS-1:0] body_length_o
);

  localparam logic [LENGTH_BITS-1:0] LenLimit = {LENGTH_BITS{1'b1}};

  typedef struct packed {
    logic [LENGTH_BITS-1:0] msg_length;
    logic                   is_frame;
    logic [7:0]             frame_channel;
    logic [LENGTH_BITS-1:0] body_length;
  } result_t;

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  logic                   interleave_q;
  rmf_pkg::phase_e        phase_q, phase_d;
  logic [LENGTH_BITS-1:0] byte_count_q, byte_count_d;
  logic [3:0]             match_pos_q, match_pos_d;
  logic [LENGTH_BITS-1:0] length_q, length_d;
  logic                   length_found_q, length_found_d;
  logic [1:0]             line_bytes_q, line_bytes_d;
  logic                   line_had_cr_q, line_had_cr_d;
  logic                   seen_nl_q, seen_nl_d;
  logic [7:0]             channel_q, channel_d;
  logic [LENGTH_BITS-1:0] body_rem_q, body_rem_d;

  logic    in_fire;
  logic    emit;
  result_t res;

  assign in_fire = in_valid_i & in_ready_o;

  // Content-Length scan and line tracking, computed from current state.
  logic [7:0]             lb;
  logic                   is_digit;
  logic [LENGTH_BITS+3:0] len_ext, times10;
  logic [LENGTH_BITS-1:0] len_sat;
  logic [3:0]             scan_pos;
  logic [LENGTH_BITS-1:0] scan_len;
  logic                   scan_found;
  logic                   trk_empty;
  logic [1:0]             trk_bytes;
  logic                   trk_cr;
  logic                   trk_seen;

  always_comb begin
    lb       = rmf_pkg::to_lower(data_byte_i);
    is_digit = (data_byte_i >= rmf_pkg::CH_ZERO) && (data_byte_i <= rmf_pkg::CH_NINE);
    len_ext  = {4'b0000, length_q};
    // value * 10 + digit as two shifts and adds
    times10  = (len_ext << 3) + (len_ext << 1)
             + (LENGTH_BITS+4)'(data_byte_i - rmf_pkg::CH_ZERO);
    len_sat  = (times10[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? LenLimit
                                                          : times10[LENGTH_BITS-1:0];

    scan_pos   = match_pos_q;
    scan_len   = length_q;
    scan_found = length_found_q;
    if (match_pos_q == rmf_pkg::POS_SKIP || match_pos_q == rmf_pkg::POS_DIGITS) begin
      if (match_pos_q == rmf_pkg::POS_SKIP &&
          (data_byte_i == rmf_pkg::CH_SPACE || data_byte_i == rmf_pkg::CH_COLON)) begin
        scan_pos = match_pos_q;
      end else if (is_digit) begin
        scan_len = len_sat;
        scan_pos = rmf_pkg::POS_DIGITS;
      end else begin
        scan_pos = 4'd0;
      end
    end else if (!length_found_q) begin
      if (lb == rmf_pkg::key_char(match_pos_q)) begin
        if (match_pos_q == rmf_pkg::KEY_LAST) begin
          scan_found = 1'b1;
          scan_pos   = rmf_pkg::POS_SKIP;
        end else begin
          scan_pos = match_pos_q + 4'd1;
        end
      end else begin
        scan_pos = (lb == rmf_pkg::key_char(4'd0)) ? 4'd1 : 4'd0;
      end
    end

    trk_empty = 1'b0;
    trk_bytes = line_bytes_q;
    trk_cr    = line_had_cr_q;
    trk_seen  = seen_nl_q;
    if (data_byte_i == rmf_pkg::CH_LF) begin
      // empty line: LF LF or LF CR LF
      if (seen_nl_q && (line_bytes_q == 2'd0 || (line_bytes_q == 2'd1 && line_had_cr_q))) begin
        trk_empty = 1'b1;
      end else begin
        trk_seen  = 1'b1;
        trk_bytes = 2'd0;
        trk_cr    = 1'b0;
      end
    end else begin
      if (line_bytes_q == 2'd0) trk_cr = (data_byte_i == rmf_pkg::CH_CR);
      if (line_bytes_q != 2'd2) trk_bytes = line_bytes_q + 2'd1;
    end
  end

  // Next-state logic
  logic                   crlf;
  logic                   first;
  logic                   clear;
  logic                   emit_frame;
  logic [LENGTH_BITS-1:0] cnt_inc;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic [LENGTH_BITS-1:0] frame_len;
  logic [LENGTH_BITS-1:0] emit_len;

  always_comb begin
    crlf      = (data_byte_i == rmf_pkg::CH_CR) || (data_byte_i == rmf_pkg::CH_LF);
    first     = (byte_count_q == '0);
    cnt_inc   = (byte_count_q != LenLimit) ? byte_count_q + 1'b1 : byte_count_q;
    rem_dec   = body_rem_q - 1'b1;
    frame_len = body_rem_q | LENGTH_BITS'(data_byte_i);

    phase_d        = phase_q;
    byte_count_d   = byte_count_q;
    match_pos_d    = match_pos_q;
    length_d       = length_q;
    length_found_d = length_found_q;
    line_bytes_d   = line_bytes_q;
    line_had_cr_d  = line_had_cr_q;
    seen_nl_d      = seen_nl_q;
    channel_d      = channel_q;
    body_rem_d     = body_rem_q;
    emit           = 1'b0;
    emit_frame     = 1'b0;
    emit_len       = length_q;
    clear          = 1'b0;

    if (in_fire) begin
      byte_count_d = cnt_inc;
      unique case (phase_q)
        rmf_pkg::PH_IDLE: begin
          // leading CR/LF is counted but starts nothing
          if (!crlf) begin
            if (first && interleave_q && data_byte_i == rmf_pkg::CH_DOLLAR) begin
              phase_d = rmf_pkg::PH_CHAN;
            end else begin
              phase_d        = rmf_pkg::PH_HEADER;
              match_pos_d    = scan_pos;
              length_d       = scan_len;
              length_found_d = scan_found;
              line_bytes_d   = trk_bytes;
              line_had_cr_d  = trk_cr;
              seen_nl_d      = trk_seen;
            end
          end
        end
        rmf_pkg::PH_HEADER: begin
          match_pos_d    = scan_pos;
          length_d       = scan_len;
          length_found_d = scan_found;
          line_bytes_d   = trk_bytes;
          line_had_cr_d  = trk_cr;
          seen_nl_d      = trk_seen;
          if (trk_empty) begin
            if (scan_len == '0) begin
              emit     = 1'b1;
              emit_len = scan_len;
            end else begin
              phase_d = rmf_pkg::PH_SKIP;
            end
          end
        end
        rmf_pkg::PH_CHAN: begin
          channel_d = data_byte_i;
          phase_d   = rmf_pkg::PH_LEN_HI;
        end
        rmf_pkg::PH_LEN_HI: begin
          body_rem_d = LENGTH_BITS'({data_byte_i, 8'h00});
          phase_d    = rmf_pkg::PH_LEN_LO;
        end
        rmf_pkg::PH_LEN_LO: begin
          length_d   = frame_len;
          body_rem_d = frame_len;
          emit_len   = frame_len;
          if (frame_len == '0) begin
            emit       = 1'b1;
            emit_frame = 1'b1;
          end else begin
            phase_d = rmf_pkg::PH_PAYLOAD;
          end
        end
        rmf_pkg::PH_PAYLOAD: begin
          body_rem_d = rem_dec;
          if (rem_dec == '0) begin
            emit       = 1'b1;
            emit_frame = 1'b1;
          end
        end
        rmf_pkg::PH_SKIP: begin
          // CR/LF after the empty line still belongs to the header
          if (!crlf) begin
            body_rem_d = length_q - 1'b1;
            if (length_q == LENGTH_BITS'(1)) begin
              emit = 1'b1;
            end else begin
              phase_d = rmf_pkg::PH_BODY;
            end
          end
        end
        rmf_pkg::PH_BODY: begin
          body_rem_d = rem_dec;
          if (rem_dec == '0) emit = 1'b1;
        end
        default: clear = 1'b1;
      endcase
    end

    if (emit || clear) begin
      phase_d        = rmf_pkg::PH_IDLE;
      byte_count_d   = '0;
      match_pos_d    = 4'd0;
      length_d       = '0;
      length_found_d = 1'b0;
      line_bytes_d   = 2'd0;
      line_had_cr_d  = 1'b0;
      seen_nl_d      = 1'b0;
      channel_d      = 8'h00;
      body_rem_d     = '0;
    end
  end

  // Result fields
  always_comb begin
    res.msg_length    = cnt_inc;
    res.is_frame      = emit_frame;
    res.frame_channel = emit_frame ? channel_q : 8'h00;
    res.body_length   = emit_len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interleave_q   <= 1'b0;
      phase_q        <= rmf_pkg::PH_IDLE;
      byte_count_q   <= '0;
      match_pos_q    <= 4'd0;
      length_q       <= '0;
      length_found_q <= 1'b0;
      line_bytes_q   <= 2'd0;
      line_had_cr_q  <= 1'b0;
      seen_nl_q      <= 1'b0;
      channel_q      <= 8'h00;
      body_rem_q     <= '0;
    end else begin
      if (cfg_we_i) interleave_q <= cfg_wdata_i;
      phase_q        <= phase_d;
      byte_count_q   <= byte_count_d;
      match_pos_q    <= match_pos_d;
      length_q       <= length_d;
      length_found_q <= length_found_d;
      line_bytes_q   <= line_bytes_d;
      line_had_cr_q  <= line_had_cr_d;
      seen_nl_q      <= seen_nl_d;
      channel_q      <= channel_d;
      body_rem_q     <= body_rem_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output buffer: output register plus one skid entry.
  // Input stalls only when both hold a result.
  // ---------------------------------------------------------------------------
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;

  assign in_ready_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = emit;
        out_d       = res;
      end
    end else if (emit) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o     = out_valid_q;
  assign msg_length_o    = out_q.msg_length;
  assign is_frame_o      = out_q.is_frame;
  assign frame_channel_o = out_q.frame_channel;
  assign body_length_o   = out_q.body_length;

endmodule

>>> design/rmf_checker.sv
module rmf_checker #(
  parameter int LENGTH_BITS = 24
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [LENGTH_BITS-1:0] msg_length_o,
  input logic                   is_frame_o,
  input logic [7:0]             frame_channel_o,
  input logic [LENGTH_BITS-1:0] body_length_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(msg_length_o)
      && $stable(body_length_o) && $stable(is_frame_o) && $stable(frame_channel_o))
    else $error("result changed while stalled");

  // Text messages carry no channel.
  a_text_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_frame_o |-> frame_channel_o == 8'h00)
    else $error("channel on a text message");

  // A frame is four header bytes plus its payload.
  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_frame_o |->
      msg_length_o == body_length_o + LENGTH_BITS'(4))
    else $error("frame length mismatch");

  // The whole message is never shorter than its body.
  a_text_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> msg_length_o >= body_length_o && msg_length_o != '0)
    else $error("message shorter than body");

endmodule

bind rtsp_message_framer_top rmf_checker #(
  .LENGTH_BITS(LENGTH_BITS)
) u_rmf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .msg_length_o   (msg_length_o),
  .is_frame_o     (is_frame_o),
  .frame_channel_o(frame_channel_o),
  .body_length_o  (body_length_o)
);

>>> verif/testbench.sv
module testbench;

  localparam int LEN_W = 24;
  localparam logic [LEN_W-1:0] LEN_LIMIT = {LEN_W{1'b1}};
  localparam int KEY_LEN = 14;
  localparam logic [8*KEY_LEN-1:0] CL_KEY = "content-length";
  // Results are registered from the last byte of a message; allow some slack.
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_BYTES = 700;

  // One completed message as the block reports it.
  typedef struct packed {
    logic [LEN_W-1:0] msg_len;
    logic             framed;
    logic [7:0]       chan;
    logic [LEN_W-1:0] pay_len;
  } framer_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_wdata_i = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [7:0]       data_byte_i = 8'h00;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [LEN_W-1:0] msg_length_o;
  logic             is_frame_o;
  logic [7:0]       frame_channel_o;
  logic [LEN_W-1:0] body_length_o;

  rtsp_message_framer_top #(
    .LENGTH_BITS(LEN_W)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .msg_length_o   (msg_length_o),
    .is_frame_o     (is_frame_o),
    .frame_channel_o(frame_channel_o),
    .body_length_o  (body_length_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Messages the parser model has closed but the block has not yet reported.
  framer_result_t expected_messages[$];
  int unsigned    faults = 0;
  int unsigned    bytes_sent = 0;
  // no_idle: both sides run back to back. sink_hold_cycles: one long
  // receiver hold-off, picked up by the result sink at its next request.
  bit             no_idle = 1'b0;
  int unsigned    sink_hold_cycles = 0;

  // ---------------------------------------------------------------------
  // Parser model: its own copy of the per-message state and the register.
  // ---------------------------------------------------------------------
  bit               interleave_on = 1'b0;
  rmf_pkg::phase_e  msg_phase = rmf_pkg::PH_IDLE;
  logic [LEN_W-1:0] msg_bytes = '0;
  logic [3:0]       key_pos = '0;
  logic [LEN_W-1:0] cl_value = '0;
  bit               cl_found = 1'b0;
  logic [1:0]       line_len = '0;
  bit               line_cr = 1'b0;
  bit               nl_seen = 1'b0;
  logic [7:0]       chan_held = '0;
  logic [LEN_W-1:0] remain = '0;

  // Case-insensitive hunt for the first Content-Length, then its digits.
  function automatic void scan_content_length(input logic [7:0] b);
    logic [7:0]  lb;
    logic [63:0] acc;
    lb = (b >= rmf_pkg::CH_UPPER_A && b <= rmf_pkg::CH_UPPER_Z) ? b + 8'd32 : b;
    if (key_pos == rmf_pkg::POS_SKIP || key_pos == rmf_pkg::POS_DIGITS) begin
      if (key_pos == rmf_pkg::POS_SKIP &&
          (b == rmf_pkg::CH_SPACE || b == rmf_pkg::CH_COLON)) return;
      if (b >= rmf_pkg::CH_ZERO && b <= rmf_pkg::CH_NINE) begin
        acc = 64'(cl_value) * 64'd10 + 64'(b - rmf_pkg::CH_ZERO);
        cl_value = (acc > 64'(LEN_LIMIT)) ? LEN_LIMIT : acc[LEN_W-1:0];
        key_pos = rmf_pkg::POS_DIGITS;
      end else begin
        key_pos = 4'd0;
      end
      return;
    end
    if (cl_found) return;
    if (lb == CL_KEY[8*(KEY_LEN-1-key_pos) +: 8]) begin
      if (key_pos == rmf_pkg::KEY_LAST) begin
        cl_found = 1'b1;
        key_pos = rmf_pkg::POS_SKIP;
      end else begin
        key_pos = key_pos + 4'd1;
      end
    end else begin
      key_pos = (lb == CL_KEY[8*(KEY_LEN-1) +: 8]) ? 4'd1 : 4'd0;
    end
  endfunction

  // True on the LF that finishes the empty line (LF LF or LF CR LF).
  function automatic bit empty_line_done(input logic [7:0] b);
    if (b == rmf_pkg::CH_LF) begin
      if (nl_seen && (line_len == 2'd0 || (line_len == 2'd1 && line_cr))) return 1'b1;
      nl_seen = 1'b1;
      line_len = 2'd0;
      line_cr = 1'b0;
      return 1'b0;
    end
    if (line_len == 2'd0) line_cr = (b == rmf_pkg::CH_CR);
    if (line_len < 2'd2) line_len = line_len + 2'd1;
    return 1'b0;
  endfunction

  function automatic bit close_message(input bit framed, output framer_result_t r);
    r.msg_len  = msg_bytes;
    r.framed   = framed;
    r.chan     = framed ? chan_held : 8'h00;
    r.pay_len  = cl_value;
    msg_phase  = rmf_pkg::PH_IDLE;
    msg_bytes  = '0;
    key_pos    = '0;
    cl_value   = '0;
    cl_found   = 1'b0;
    line_len   = '0;
    line_cr    = 1'b0;
    nl_seen    = 1'b0;
    chan_held  = '0;
    remain     = '0;
    return 1'b1;
  endfunction

  // Advance the model by one accepted byte; true when a message completes.
  function automatic bit advance_parser(input logic [7:0] b, output framer_result_t r);
    bit crlf;
    bit first;
    crlf = (b == rmf_pkg::CH_CR || b == rmf_pkg::CH_LF);
    first = (msg_bytes == '0);
    r = '0;
    if (msg_bytes < LEN_LIMIT) msg_bytes = msg_bytes + 1'b1;
    case (msg_phase)
      rmf_pkg::PH_IDLE: begin
        if (crlf) return 1'b0;
        if (first && interleave_on && b == rmf_pkg::CH_DOLLAR) begin
          msg_phase = rmf_pkg::PH_CHAN;
          return 1'b0;
        end
        msg_phase = rmf_pkg::PH_HEADER;
        scan_content_length(b);
        void'(empty_line_done(b));
        return 1'b0;
      end
      rmf_pkg::PH_HEADER: begin
        scan_content_length(b);
        if (!empty_line_done(b)) return 1'b0;
        if (cl_value == '0) return close_message(1'b0, r);
        msg_phase = rmf_pkg::PH_SKIP;
        return 1'b0;
      end
      rmf_pkg::PH_CHAN: begin
        chan_held = b;
        msg_phase = rmf_pkg::PH_LEN_HI;
        return 1'b0;
      end
      rmf_pkg::PH_LEN_HI: begin
        remain = LEN_W'({b, 8'h00});
        msg_phase = rmf_pkg::PH_LEN_LO;
        return 1'b0;
      end
      rmf_pkg::PH_LEN_LO: begin
        cl_value = remain | LEN_W'(b);
        remain = cl_value;
        if (cl_value == '0) return close_message(1'b1, r);
        msg_phase = rmf_pkg::PH_PAYLOAD;
        return 1'b0;
      end
      rmf_pkg::PH_PAYLOAD: begin
        remain = remain - 1'b1;
        if (remain == '0) return close_message(1'b1, r);
        return 1'b0;
      end
      rmf_pkg::PH_SKIP: begin
        if (crlf) return 1'b0;
        remain = cl_value - 1'b1;
        if (remain == '0) return close_message(1'b0, r);
        msg_phase = rmf_pkg::PH_BODY;
        return 1'b0;
      end
      rmf_pkg::PH_BODY: begin
        remain = remain - 1'b1;
        if (remain == '0) return close_message(1'b0, r);
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Byte sender. Returns at the rising edge that accepted the request; the
  // next call (or settle_stream) decides at the following falling edge
  // whether valid stays up for a new byte or drops.
  // ---------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    int unsigned    gap;
    framer_result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (advance_parser(b, r)) expected_messages.push_back(r);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  // Drop valid, let every pending result drain, then allow for bytes that
  // produce no result but may still be in flight.
  task automatic settle_stream();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_messages.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_interleave(input bit en);
    settle_stream();
    cfg_wdata_i <= en;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    interleave_on = en;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Result sink: random stall per request, plus the one long hold-off.
  // ---------------------------------------------------------------------
  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      faults++;
    end
  endtask

  initial begin : result_sink
    int unsigned    stall;
    framer_result_t want;
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_messages.size() == 0) begin
        $display("%0t: unexpected result, expected none actual msg_length %0d body %0d",
                 $time, msg_length_o, body_length_o);
        faults++;
      end else begin
        want = expected_messages.pop_front();
        check_field("msg_length", want.msg_len, msg_length_o);
        check_field("is_frame", want.framed, is_frame_o);
        check_field("frame_channel", want.chan, frame_channel_o);
        check_field("body_length", want.pay_len, body_length_o);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Random message builders
  // ---------------------------------------------------------------------
  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) ? "a" : rmf_pkg::CH_UPPER_A) + 8'($urandom_range(0, 25));
  endfunction

  task automatic send_eol();
    if ($urandom_range(0, 1)) send_byte(rmf_pkg::CH_CR);
    send_byte(rmf_pkg::CH_LF);
  endtask

  // Key in random letter case, then spaces/colons and a value of some form.
  task automatic send_length_header();
    logic [7:0] c;
    int         k;
    for (k = 0; k < KEY_LEN; k++) begin
      c = CL_KEY[8*(KEY_LEN-1-k) +: 8];
      if (c != "-" && $urandom_range(0, 1)) c = c - 8'd32;
      send_byte(c);
    end
    repeat ($urandom_range(0, 3))
      send_byte($urandom_range(0, 1) ? rmf_pkg::CH_SPACE : rmf_pkg::CH_COLON);
    case ($urandom_range(0, 9))
      0: send_text($sformatf("-%0d", $urandom_range(1, 9)));
      1: send_text($sformatf("+%0d", $urandom_range(1, 9)));
      2: ;
      3: send_text($sformatf("00%0d", $urandom_range(0, 30)));
      default: send_text($sformatf("%0d", $urandom_range(0, 30)));
    endcase
  endtask

  task automatic send_text_message();
    int unsigned budget;
    // leading CR/LF now and then
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 2))
        send_byte($urandom_range(0, 1) ? rmf_pkg::CH_CR : rmf_pkg::CH_LF);
    repeat ($urandom_range(1, 6)) send_byte(rand_letter());
    send_eol();
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 2) == 0) begin
        send_length_header();
      end else begin
        repeat ($urandom_range(1, 5)) send_byte(rand_letter());
        send_byte(rmf_pkg::CH_COLON);
        send_byte(rmf_pkg::CH_SPACE);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(32, 126)));
      end
      send_eol();
    end
    send_eol();
    // body; occasionally cut short so the next message lands inside it
    if (msg_phase == rmf_pkg::PH_SKIP && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2))
        send_byte($urandom_range(0, 1) ? rmf_pkg::CH_CR : rmf_pkg::CH_LF);
    budget = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 10) : 32'hFFFF_FFFF;
    while ((msg_phase == rmf_pkg::PH_SKIP || msg_phase == rmf_pkg::PH_BODY) &&
           budget != 0) begin
      send_byte(8'($urandom_range(0, 255)));
      budget--;
    end
  endtask

  task automatic send_dollar_frame();
    int unsigned len;
    int unsigned budget;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(256, 600) : $urandom_range(0, 40);
    send_byte(rmf_pkg::CH_DOLLAR);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    budget = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 10) : 32'hFFFF_FFFF;
    while (msg_phase == rmf_pkg::PH_PAYLOAD && budget != 0) begin
      send_byte(8'($urandom_range(0, 255)));
      budget--;
    end
  endtask

  // Junk bytes; never opens a frame, so no long payload can result.
  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 12)) begin
      b = $urandom_range(0, 255);
      if (msg_phase == rmf_pkg::PH_IDLE && msg_bytes == '0 && b == rmf_pkg::CH_DOLLAR)
        b = rmf_pkg::CH_SPACE;
      send_byte(b);
    end
  endtask

  // Push the stream to a message boundary before the next well-formed one.
  task automatic resync_stream();
    while (msg_phase != rmf_pkg::PH_IDLE || msg_bytes != '0) begin
      case (msg_phase)
        rmf_pkg::PH_IDLE:   send_byte("z");
        rmf_pkg::PH_HEADER: send_byte(rmf_pkg::CH_LF);
        rmf_pkg::PH_LEN_HI: send_byte(8'h00);
        default:            send_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Both empty-line forms, leading CR/LF, and CR/LF trailing a bodiless
  // message that become leading bytes of the next one.
  task automatic test_text_endings();
    set_interleave(1'b0);
    send_text("A\n\n");
    send_text("OPTIONS * RTSP/1.0\015\nCSeq: 1\015\n\015\n");
    send_text("\015\n\015X\n\n");
    send_text("Q\n\n\015\n\015");
    send_text("R\n\015\n");
  endtask

  // Frames with payload, empty frame, '$' after leading CR/LF, '$' with
  // interleaving off.
  task automatic test_dollar_frames();
    set_interleave(1'b1);
    send_byte(rmf_pkg::CH_DOLLAR);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h03);
    send_text("abc");
    send_byte(rmf_pkg::CH_DOLLAR);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(rmf_pkg::CH_DOLLAR);
    send_byte(8'h5A);
    send_byte(8'h00);
    send_byte(8'h04);
    send_text("$\n\n$");
    send_text("\n$x\n\n");
    set_interleave(1'b0);
    send_text("$ab\n\n");
  endtask

  task automatic test_content_length();
    set_interleave(1'b0);
    send_text("ANNOUNCE\nContent-Length: 12\n\nhello world!");
    // separators, leading zeros, CR/LF after the empty line
    send_text("X\015\ncOnTeNt-LeNgTh:: :007\015\n\015\n\015\n\015abcdefg");
    // single body byte closes the message straight out of the skip state
    send_text("Y\nContent-Length: 1\n\n!");
    send_text("Z\nContent-Length: -5\n\n");
    send_text("Z\nContent-Length:\n\n");
    send_text("W\nContent-Length: 2\nContent-Length: 9\n\nok");
    send_text("V\nccontent-lengtH 3\n\nabc");
    send_text("U\nContent-Length: 2x5\n\nab");
    send_text("Content-Length: 4\n\nbody");
  endtask

  // The register is only looked at on a message's first byte.
  task automatic test_config_mid_message();
    set_interleave(1'b1);
    send_byte(rmf_pkg::CH_DOLLAR);
    send_byte(8'h07);
    send_byte(8'h00);
    set_interleave(1'b0);
    send_byte(8'h02);
    send_text("hi");
    send_text("M");
    set_interleave(1'b1);
    send_text("\n\n");
  endtask

  // Mostly well-formed messages with random content; some noise, cut
  // messages, idle-free stretches and register changes along the way.
  task automatic test_random_traffic();
    int unsigned start;
    int unsigned next_cfg;
    int unsigned pick;
    start = bytes_sent;
    next_cfg = start + 250;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 4) == 0) no_idle = !no_idle;
      resync_stream();
      pick = $urandom_range(0, 99);
      if (pick < 50) send_text_message();
      else if (pick < 85) send_dollar_frame();
      else send_noise();
      if (bytes_sent >= next_cfg) begin
        set_interleave($urandom_range(0, 1));
        next_cfg = bytes_sent + 250;
      end
    end
    no_idle = 1'b0;
  endtask

  // Receiver holds off while empty frames keep coming: the output buffer
  // fills and the input must stall.
  task automatic test_output_backpressure();
    set_interleave(1'b1);
    no_idle = 1'b1;
    sink_hold_cycles = 300;
    repeat (30) begin
      send_byte(rmf_pkg::CH_DOLLAR);
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'h00);
      send_byte(8'h00);
    end
    no_idle = 1'b0;
  endtask

  // Long frame with both length bytes in use.
  task automatic test_longest_frame();
    set_interleave(1'b1);
    no_idle = 1'b1;
    send_byte(rmf_pkg::CH_DOLLAR);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'hFF);
    while (msg_phase == rmf_pkg::PH_PAYLOAD) send_byte(8'($urandom_range(0, 255)));
    no_idle = 1'b0;
  endtask

  // Saturated Content-Length: the body would run past the end of the run,
  // so this message is left open and nothing is expected from it.
  task automatic test_length_saturation();
    set_interleave(1'b0);
    send_text("S\nContent-Length: 99999999999\n\nabc");
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    int k;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_text_endings();
    test_dollar_frames();
    test_content_length();
    test_config_mid_message();
    test_random_traffic();
    test_output_backpressure();
    test_longest_frame();
    test_length_saturation();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    for (k = 0; k < 4000 && expected_messages.size() != 0; k++) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_messages.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_messages.size());
      faults++;
    end
    if (faults == 0) begin
      $display("PASS rtsp_message_framer_top");
    end else begin
      $display("FAIL rtsp_message_framer_top");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #2000000;
    $display("FAIL rtsp_message_framer_top");
    $finish;
  end

endmodule
